// ===== src/dual_site_set_table_macros.svh =====
// Assertion macros shared by the checker of the site set table.
`ifndef DUAL_SITE_SET_TABLE_MACROS_SVH
`define DUAL_SITE_SET_TABLE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DSST_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed in the site set table");

// The consequent must hold in the cycle after the antecedent.
`define DSST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed in the site set table");

`endif

// ===== src/dsst_pkg.sv =====
// Types and codes of the dual site set table.
package dsst_pkg;

	localparam int COUNT_W = 11;

	localparam logic [2:0] OP_ADD_GROWTH     = 3'd0;
	localparam logic [2:0] OP_ADD_DISS       = 3'd1;
	localparam logic [2:0] OP_REM_GROWTH_POS = 3'd2;
	localparam logic [2:0] OP_REM_GROWTH_ID  = 3'd3;
	localparam logic [2:0] OP_REM_DISS_POS   = 3'd4;
	localparam logic [2:0] OP_REM_DISS_ID    = 3'd5;

	localparam logic [2:0] STATUS_DONE     = 3'd0;
	localparam logic [2:0] STATUS_PRESENT  = 3'd1;
	localparam logic [2:0] STATUS_NOTFOUND = 3'd2;
	localparam logic [2:0] STATUS_FULL     = 3'd3;
	localparam logic [2:0] STATUS_POSITION = 3'd4;

	typedef struct packed {
		logic [2:0]         op;
		logic [23:0]        site_id;
		logic signed [15:0] affinity;
		logic [9:0]         position;
	} cmd_t;

	typedef struct packed {
		logic [2:0]         status;
		logic [COUNT_W-1:0] growth_count;
		logic [COUNT_W-1:0] dissolution_count;
	} res_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SEARCH,
		S_READ_POS,
		S_CHECK_POS,
		S_MOVE,
		S_DONE
	} state_t;

endpackage

// ===== src/dsst_ram.sv =====
// Simple dual-port RAM with one write port and a registered read port.
module dsst_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== src/dual_site_set_table.sv =====
// Dual site set table: two swap-remove sets of site ids, one with affinities.
//
// An item enters on the cmd channel when cmd_valid is high and cmd_stall low.
// It names an operation, a site id, an affinity and a position. Each item
// gives exactly one item on the res channel: a status and both set counts as
// they stand after the operation.
// The block works on one item at a time and holds cmd_stall high until the
// result has been loaded into the output register. Adds and removes by id
// scan the selected table one entry per cycle through the registered read
// port of its RAM; a successful remove then moves the last entry into the
// hole. A remove at a position checks the position against the count,
// reads the entry there and compares its id, and on a match moves the last
// entry into its place.
// The output register lets the next item enter while a result still waits;
// if res_stall stays high the sequencer waits with its finished result until
// the register is free. Reset empties both sets at once; the RAM contents
// need no clearing because only entries below a count are ever read.
module dual_site_set_table #(
	parameter int TABLE_DEPTH   = 1024,
	parameter int ID_BITS       = 24,
	parameter int AFFINITY_BITS = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_stall,
	input  dsst_pkg::cmd_t cmd,
	output logic           res_valid,
	input  logic           res_stall,
	output dsst_pkg::res_t res
);

	localparam int ADDR_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
	localparam int GROW_W = ID_BITS + AFFINITY_BITS;

	dsst_pkg::state_t state_q, state_d;

	logic [2:0]               op_q;
	logic [ID_BITS-1:0]       id_q;
	logic [AFFINITY_BITS-1:0] aff_q;
	logic [9:0]               pos_q;
	logic                     dis_q;
	logic [CNT_W-1:0]         g_cnt_q, d_cnt_q;
	logic [CNT_W-1:0]         addr_q;
	logic                     pend_q;
	logic [ADDR_W-1:0]        pidx_q;
	logic [ADDR_W-1:0]        hole_q;
	logic [2:0]               status_q;
	logic                     res_valid_q;
	dsst_pkg::res_t           res_q;

	logic                     accept;
	logic [63:0]              id_wide;
	logic signed [63:0]       aff_wide;
	logic [31:0]              pos_wide;
	logic [ADDR_W-1:0]        pos_idx;
	logic [CNT_W-1:0]         cnt_sel;
	logic [CNT_W-1:0]         cnt_less;
	logic [ADDR_W-1:0]        last_idx;
	logic                     is_add;
	logic                     full;
	logic [ID_BITS-1:0]       rd_id;
	logic                     match;
	logic [31:0]              g_wide, d_wide;

	logic [ADDR_W-1:0]        rd_addr;
	logic [ADDR_W-1:0]        wr_addr;
	logic                     wr_en;
	logic                     move;
	logic                     issue;
	logic                     hole_ld;
	logic                     status_ld;
	logic [2:0]               status_d;
	logic                     cnt_inc, cnt_dec;
	logic                     out_load;

	logic                     g_we, d_we;
	logic [GROW_W-1:0]        g_wdata, g_rdata;
	logic [ID_BITS-1:0]       d_wdata, d_rdata;

	assign accept    = cmd_valid && !cmd_stall;
	assign cmd_stall = (state_q != dsst_pkg::S_IDLE);
	assign id_wide   = 64'(cmd.site_id);
	assign aff_wide  = 64'(cmd.affinity);
	assign pos_wide  = 32'(pos_q);
	assign pos_idx   = pos_wide[ADDR_W-1:0];
	assign cnt_sel   = dis_q ? d_cnt_q : g_cnt_q;
	assign cnt_less  = cnt_sel - CNT_W'(1);
	assign last_idx  = cnt_less[ADDR_W-1:0];
	assign is_add    = op_q inside {dsst_pkg::OP_ADD_GROWTH, dsst_pkg::OP_ADD_DISS};
	assign full      = 32'(cnt_sel) >= 32'(TABLE_DEPTH);
	assign rd_id     = dis_q ? d_rdata : g_rdata[GROW_W-1:AFFINITY_BITS];
	assign match     = (rd_id == id_q);

	assign g_we    = wr_en && !dis_q;
	assign d_we    = wr_en && dis_q;
	assign g_wdata = move ? g_rdata : {id_q, aff_q};
	assign d_wdata = move ? d_rdata : id_q;

	always_comb begin
		state_d   = state_q;
		status_d  = dsst_pkg::STATUS_NOTFOUND;
		status_ld = 1'b0;
		rd_addr   = addr_q[ADDR_W-1:0];
		wr_addr   = cnt_sel[ADDR_W-1:0];
		wr_en     = 1'b0;
		move      = 1'b0;
		issue     = 1'b0;
		hole_ld   = 1'b0;
		cnt_inc   = 1'b0;
		cnt_dec   = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			dsst_pkg::S_IDLE: begin
				if (accept) begin
					case (cmd.op)
						dsst_pkg::OP_ADD_GROWTH, dsst_pkg::OP_ADD_DISS,
						dsst_pkg::OP_REM_GROWTH_ID, dsst_pkg::OP_REM_DISS_ID: begin
							state_d = dsst_pkg::S_SEARCH;
						end
						dsst_pkg::OP_REM_GROWTH_POS, dsst_pkg::OP_REM_DISS_POS: begin
							state_d = dsst_pkg::S_READ_POS;
						end
						default: begin
							status_ld = 1'b1;
							state_d   = dsst_pkg::S_DONE;
						end
					endcase
				end
			end
			dsst_pkg::S_SEARCH: begin
				if (pend_q && match) begin
					status_ld = 1'b1;
					if (is_add) begin
						status_d = dsst_pkg::STATUS_PRESENT;
						state_d  = dsst_pkg::S_DONE;
					end else begin
						hole_ld = 1'b1;
						rd_addr = last_idx;
						state_d = dsst_pkg::S_MOVE;
					end
				end else if (cnt_sel == '0 || (pend_q && pidx_q == last_idx)) begin
					status_ld = 1'b1;
					state_d   = dsst_pkg::S_DONE;
					if (is_add) begin
						if (full) begin
							status_d = dsst_pkg::STATUS_FULL;
						end else begin
							status_d = dsst_pkg::STATUS_DONE;
							wr_en    = 1'b1;
							cnt_inc  = 1'b1;
						end
					end
				end else begin
					issue = 1'b1;
				end
			end
			dsst_pkg::S_READ_POS: begin
				if (pos_wide >= 32'(cnt_sel)) begin
					status_ld = 1'b1;
					status_d  = dsst_pkg::STATUS_POSITION;
					state_d   = dsst_pkg::S_DONE;
				end else begin
					rd_addr = pos_idx;
					state_d = dsst_pkg::S_CHECK_POS;
				end
			end
			dsst_pkg::S_CHECK_POS: begin
				if (match) begin
					hole_ld = 1'b1;
					rd_addr = last_idx;
					state_d = dsst_pkg::S_MOVE;
				end else begin
					status_ld = 1'b1;
					state_d   = dsst_pkg::S_DONE;
				end
			end
			dsst_pkg::S_MOVE: begin
				move      = 1'b1;
				wr_en     = 1'b1;
				wr_addr   = hole_q;
				cnt_dec   = 1'b1;
				status_ld = 1'b1;
				status_d  = dsst_pkg::STATUS_DONE;
				state_d   = dsst_pkg::S_DONE;
			end
			dsst_pkg::S_DONE: begin
				if (!res_valid_q || !res_stall) begin
					out_load = 1'b1;
					state_d  = dsst_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = dsst_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dsst_pkg::S_IDLE;
			g_cnt_q     <= '0;
			d_cnt_q     <= '0;
			pend_q      <= 1'b0;
			addr_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				pend_q <= 1'b0;
				addr_q <= '0;
			end else if (issue) begin
				pend_q <= 1'b1;
				addr_q <= addr_q + CNT_W'(1);
			end
			if (cnt_inc && !dis_q) begin
				g_cnt_q <= g_cnt_q + CNT_W'(1);
			end else if (cnt_dec && !dis_q) begin
				g_cnt_q <= g_cnt_q - CNT_W'(1);
			end
			if (cnt_inc && dis_q) begin
				d_cnt_q <= d_cnt_q + CNT_W'(1);
			end else if (cnt_dec && dis_q) begin
				d_cnt_q <= d_cnt_q - CNT_W'(1);
			end
			if (out_load) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign g_wide = 32'(g_cnt_q);
	assign d_wide = 32'(d_cnt_q);

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= cmd.op;
			id_q  <= id_wide[ID_BITS-1:0];
			aff_q <= aff_wide[AFFINITY_BITS-1:0];
			pos_q <= cmd.position;
			dis_q <= cmd.op inside {dsst_pkg::OP_ADD_DISS, dsst_pkg::OP_REM_DISS_POS,
				dsst_pkg::OP_REM_DISS_ID};
		end
		if (issue) begin
			pidx_q <= addr_q[ADDR_W-1:0];
		end
		if (hole_ld) begin
			hole_q <= (state_q == dsst_pkg::S_SEARCH) ? pidx_q : pos_idx;
		end
		if (status_ld) begin
			status_q <= status_d;
		end
		if (out_load) begin
			res_q.status            <= status_q;
			res_q.growth_count      <= g_wide[dsst_pkg::COUNT_W-1:0];
			res_q.dissolution_count <= d_wide[dsst_pkg::COUNT_W-1:0];
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	dsst_ram #(
		.WIDTH(GROW_W),
		.DEPTH(TABLE_DEPTH)
	) u_growth_ram (
		.clk  (clk),
		.we   (g_we),
		.waddr(wr_addr),
		.wdata(g_wdata),
		.raddr(rd_addr),
		.rdata(g_rdata)
	);

	dsst_ram #(
		.WIDTH(ID_BITS),
		.DEPTH(TABLE_DEPTH)
	) u_diss_ram (
		.clk  (clk),
		.we   (d_we),
		.waddr(wr_addr),
		.wdata(d_wdata),
		.raddr(rd_addr),
		.rdata(d_rdata)
	);

endmodule

// ===== src/dsst_checker.sv =====
// Port-level checker of the dual site set table and its bind.
`include "dual_site_set_table_macros.svh"

module dsst_checker #(
	parameter int TABLE_DEPTH = 1024
) (
	input logic           clk,
	input logic           arst_n,
	input logic           cmd_valid,
	input logic           cmd_stall,
	input logic           res_valid,
	input logic           res_stall,
	input dsst_pkg::res_t res
);

	// An accepted item keeps the block busy for at least the next cycle.
	`DSST_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, cmd_valid && !cmd_stall, cmd_stall)

	// A result appears only after the block was busy.
	`DSST_ASSERT_NOW(a_result_from_busy, clk, arst_n, $rose(res_valid), $past(cmd_stall))

	// Neither set ever reports more entries than a table holds.
	`DSST_ASSERT_NOW(a_count_bound, clk, arst_n, res_valid,
		32'(res.growth_count) <= TABLE_DEPTH && 32'(res.dissolution_count) <= TABLE_DEPTH)

	// A stalled result stays offered and unchanged.
	`DSST_ASSERT_NEXT(a_result_held, clk, arst_n, res_valid && res_stall,
		res_valid && $stable(res))

endmodule

bind dual_site_set_table dsst_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_dsst_checker (.*);

// ===== dv/dual_site_set_table_tb.sv =====
// Testbench of the dual site set table: random and directed commands checked against a predictor.
module dual_site_set_table_tb;

	localparam int TABLE_SLOTS = 1024;
	localparam int CW = dsst_pkg::COUNT_W;
	localparam int PLAN = 0;
	localparam int LIVE = 1;
	localparam int SET_GROWTH = 0;
	localparam int SET_DISS = 1;
	localparam logic [2:0] OP_RESERVED_6 = 3'd6;
	localparam logic [2:0] OP_RESERVED_7 = 3'd7;
	localparam int RANDOM_ITEMS = 560;
	localparam int DRAIN_ITEM = 300;
	localparam int LONG_HOLD_AT = 90;
	localparam int LONG_HOLD_CYCLES = 400;
	localparam int SETTLE_CYCLES = 1100;
	localparam int PRINT_LIMIT = 50;

	typedef struct {
		dsst_pkg::cmd_t c;
		int             gap;
		bit             drain;
	} queued_cmd_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_stall;
	dsst_pkg::cmd_t cmd = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	dsst_pkg::res_t res;

	// Two copies of both sets: one follows the command stream as it is planned,
	// the other follows the commands as the block accepts them.
	bit [23:0] site_ids [2][2][TABLE_SLOTS];
	int site_count [2][2];

	queued_cmd_t pending_cmds [$];
	dsst_pkg::res_t expected_results [$];
	dsst_pkg::res_t want;
	int send_hold = 0;
	int recv_wait = 0;
	bit recv_quiet = 1'b0;
	int cmds_accepted = 0;
	int results_seen = 0;
	int mismatches = 0;

	dual_site_set_table uut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd(cmd),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic dsst_pkg::res_t apply_op(input int cp, input dsst_pkg::cmd_t c);
		dsst_pkg::res_t r;
		int s;
		int n;
		int hit;
		r.status = dsst_pkg::STATUS_NOTFOUND;
		s = (c.op == dsst_pkg::OP_ADD_DISS || c.op == dsst_pkg::OP_REM_DISS_POS ||
			c.op == dsst_pkg::OP_REM_DISS_ID) ? SET_DISS : SET_GROWTH;
		n = site_count[cp][s];
		hit = n;
		for (int i = 0; i < n; i++) begin
			if (hit == n && site_ids[cp][s][i] == c.site_id)
				hit = i;
		end
		case (c.op)
			dsst_pkg::OP_ADD_GROWTH, dsst_pkg::OP_ADD_DISS: begin
				if (hit < n) begin
					r.status = dsst_pkg::STATUS_PRESENT;
				end else if (n >= TABLE_SLOTS) begin
					r.status = dsst_pkg::STATUS_FULL;
				end else begin
					site_ids[cp][s][n] = c.site_id;
					site_count[cp][s] = n + 1;
					r.status = dsst_pkg::STATUS_DONE;
				end
			end
			dsst_pkg::OP_REM_GROWTH_POS, dsst_pkg::OP_REM_DISS_POS: begin
				if (int'(c.position) >= n) begin
					r.status = dsst_pkg::STATUS_POSITION;
				end else if (site_ids[cp][s][c.position] != c.site_id) begin
					r.status = dsst_pkg::STATUS_NOTFOUND;
				end else begin
					site_ids[cp][s][c.position] = site_ids[cp][s][n - 1];
					site_count[cp][s] = n - 1;
					r.status = dsst_pkg::STATUS_DONE;
				end
			end
			dsst_pkg::OP_REM_GROWTH_ID, dsst_pkg::OP_REM_DISS_ID: begin
				if (hit < n) begin
					site_ids[cp][s][hit] = site_ids[cp][s][n - 1];
					site_count[cp][s] = n - 1;
					r.status = dsst_pkg::STATUS_DONE;
				end
			end
			default: begin
				r.status = dsst_pkg::STATUS_NOTFOUND;
			end
		endcase
		r.growth_count = CW'(site_count[cp][SET_GROWTH]);
		r.dissolution_count = CW'(site_count[cp][SET_DISS]);
		return r;
	endfunction

	function automatic dsst_pkg::cmd_t make_cmd(input logic [2:0] op, input logic [23:0] id,
			input logic signed [15:0] aff, input logic [9:0] pos);
		dsst_pkg::cmd_t c;
		c.op = op;
		c.site_id = id;
		c.affinity = aff;
		c.position = pos;
		return c;
	endfunction

	task automatic queue_cmd(input dsst_pkg::cmd_t c, input int gap, input bit drain);
		queued_cmd_t q;
		void'(apply_op(PLAN, c));
		q.c = c;
		q.gap = gap;
		q.drain = drain;
		pending_cmds.insert(pending_cmds.size(), q);
	endtask

	task automatic queue_now(input logic [2:0] op, input logic [23:0] id,
			input logic signed [15:0] aff, input logic [9:0] pos);
		queue_cmd(make_cmd(op, id, aff, pos), $urandom_range(0, 15), 1'b0);
	endtask

	function automatic dsst_pkg::cmd_t random_cmd();
		dsst_pkg::cmd_t c;
		int s;
		int n;
		int pick;
		int slot;
		c = make_cmd(dsst_pkg::OP_ADD_GROWTH, 24'($urandom()), 16'($urandom()),
			10'($urandom()));
		s = $urandom_range(0, 1);
		n = site_count[PLAN][s];
		pick = $urandom_range(0, 99);
		if (pick < (n < 48 ? 55 : 20)) begin
			c.op = (s == SET_DISS) ? dsst_pkg::OP_ADD_DISS : dsst_pkg::OP_ADD_GROWTH;
			if (n > 0 && $urandom_range(0, 3) == 0)
				c.site_id = site_ids[PLAN][s][$urandom_range(0, n - 1)];
		end else if (pick < 75) begin
			c.op = (s == SET_DISS) ? dsst_pkg::OP_REM_DISS_POS : dsst_pkg::OP_REM_GROWTH_POS;
			if (n > 0) begin
				slot = $urandom_range(0, n - 1);
				c.position = 10'(slot);
				c.site_id = site_ids[PLAN][s][slot];
			end
		end else if (pick < 90) begin
			c.op = (s == SET_DISS) ? dsst_pkg::OP_REM_DISS_ID : dsst_pkg::OP_REM_GROWTH_ID;
			if (n > 0)
				c.site_id = site_ids[PLAN][s][$urandom_range(0, n - 1)];
		end else begin
			case ($urandom_range(0, 2))
				0: c.op = 3'($urandom_range(0, 7));
				1: begin
					c.op = (s == SET_DISS) ? dsst_pkg::OP_REM_DISS_POS :
						dsst_pkg::OP_REM_GROWTH_POS;
					c.position = 10'($urandom_range(n, TABLE_SLOTS - 1));
				end
				default: begin
					c.op = (s == SET_DISS) ? dsst_pkg::OP_REM_DISS_POS :
						dsst_pkg::OP_REM_GROWTH_POS;
					if (n > 0) begin
						slot = $urandom_range(0, n - 1);
						c.position = 10'(slot);
						c.site_id = site_ids[PLAN][s][slot] ^ (24'd1 << $urandom_range(0, 23));
					end
				end
			endcase
		end
		return c;
	endfunction

	task automatic report_mismatch(input string what);
		mismatches++;
		if (mismatches <= PRINT_LIMIT)
			$display("MISMATCH at %0t: %s", $time, what);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid <= 1'b0;
		end else begin
			if (cmd_valid && !cmd_stall) begin
				expected_results.insert(expected_results.size(), apply_op(LIVE, cmd));
				cmds_accepted++;
			end
			if (!cmd_valid || !cmd_stall) begin
				if (pending_cmds.size() == 0 ||
						(pending_cmds[0].drain && expected_results.size() > 0)) begin
					cmd_valid <= 1'b0;
				end else if (send_hold < pending_cmds[0].gap) begin
					send_hold++;
					cmd_valid <= 1'b0;
				end else begin
					cmd <= pending_cmds[0].c;
					cmd_valid <= 1'b1;
					void'(pending_cmds.pop_front());
					send_hold = 0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
		end else begin
			if (res_valid && !res_stall) begin
				if (expected_results.size() == 0) begin
					report_mismatch("result arrived with no command outstanding");
				end else begin
					want = expected_results.pop_front();
					if (res.status !== want.status)
						report_mismatch($sformatf("result %0d: status %0d, expected %0d",
							results_seen, res.status, want.status));
					if (res.growth_count !== want.growth_count)
						report_mismatch($sformatf("result %0d: growth count %0d, expected %0d",
							results_seen, res.growth_count, want.growth_count));
					if (res.dissolution_count !== want.dissolution_count)
						report_mismatch($sformatf(
							"result %0d: dissolution count %0d, expected %0d",
							results_seen, res.dissolution_count, want.dissolution_count));
				end
				results_seen++;
				if (results_seen % 40 == 0)
					recv_quiet = ($urandom_range(0, 2) == 0);
				recv_wait = recv_quiet ? 0 : $urandom_range(0, 15);
				if (results_seen == LONG_HOLD_AT)
					recv_wait = LONG_HOLD_CYCLES;
			end
			res_stall <= (recv_wait > 0);
			if (recv_wait > 0)
				recv_wait--;
		end
	end

	initial begin
		#150000000;
		$display("[dual_site_set_table] ERROR");
		$finish;
	end

	initial begin
		bit quiet;
		int gap;

		// Empty tables, undefined codes and the extremes of every field.
		queue_now(OP_RESERVED_6, 24'hFFFFFF, 16'sh7FFF, 10'h3FF);
		queue_now(OP_RESERVED_7, 24'h000000, -16'sd32768, 10'h000);
		queue_now(dsst_pkg::OP_REM_GROWTH_ID, 24'h000000, 16'sd0, 10'h000);
		queue_now(dsst_pkg::OP_REM_GROWTH_POS, 24'h000000, 16'sd0, 10'h000);
		queue_now(dsst_pkg::OP_REM_DISS_POS, 24'hFFFFFF, 16'sd0, 10'h3FF);
		queue_now(dsst_pkg::OP_REM_DISS_ID, 24'hFFFFFF, 16'sd0, 10'h000);
		queue_now(dsst_pkg::OP_ADD_GROWTH, 24'h000000, -16'sd32768, 10'h000);
		queue_now(dsst_pkg::OP_ADD_GROWTH, 24'hFFFFFF, 16'sh7FFF, 10'h3FF);
		queue_now(dsst_pkg::OP_ADD_GROWTH, 24'h000000, 16'sd1, 10'h000);
		queue_now(dsst_pkg::OP_ADD_DISS, 24'hFFFFFF, -16'sd1, 10'h3FF);
		queue_now(dsst_pkg::OP_ADD_DISS, 24'h000000, 16'sd0, 10'h000);
		queue_now(dsst_pkg::OP_ADD_DISS, 24'h000000, 16'sd0, 10'h000);
		queue_now(dsst_pkg::OP_REM_GROWTH_POS, 24'hFFFFFF, 16'sd0, 10'h000);
		queue_now(dsst_pkg::OP_REM_GROWTH_POS, 24'h000000, 16'sd0, 10'h002);
		queue_now(dsst_pkg::OP_REM_GROWTH_POS, 24'h000000, 16'sd0, 10'h000);
		queue_now(dsst_pkg::OP_REM_DISS_ID, 24'hFFFFFF, 16'sd0, 10'h000);
		queue_now(dsst_pkg::OP_REM_DISS_ID, 24'h000123, 16'sd0, 10'h000);
		queue_now(dsst_pkg::OP_ADD_GROWTH, 24'h000005, -16'sd1, 10'h000);
		queue_now(dsst_pkg::OP_REM_GROWTH_ID, 24'hFFFFFF, 16'sd0, 10'h000);
		queue_now(dsst_pkg::OP_REM_DISS_POS, 24'h000000, 16'sd0, 10'h000);
		queue_now(dsst_pkg::OP_REM_GROWTH_POS, 24'h000005, 16'sd0, 10'h000);
		queue_now(OP_RESERVED_7, 24'hFFFFFF, -16'sd1, 10'h3FF);

		quiet = 1'b0;
		for (int k = 0; k < RANDOM_ITEMS; k++) begin
			if (k % 40 == 0)
				quiet = ($urandom_range(0, 2) == 0);
			gap = (quiet || (k >= 60 && k < 110)) ? 0 : $urandom_range(0, 15);
			queue_cmd(random_cmd(), gap, k == DRAIN_ITEM);
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_cmds.size() > 0 || cmd_valid || expected_results.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (expected_results.size() > 0)
			report_mismatch($sformatf("%0d results never arrived", expected_results.size()));

		$display("Ran %0d commands and checked %0d results over both sets and every operation,",
			cmds_accepted, results_seen);
		$display("including undefined codes, empty-set removes, a long result stall and a drain.");
		if (mismatches == 0) begin
			$display("[dual_site_set_table] OK");
		end else begin
			$display("[dual_site_set_table] ERROR");
		end
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+src
src/dsst_pkg.sv
src/dsst_ram.sv
src/dual_site_set_table.sv
src/dsst_checker.sv
dv/dual_site_set_table_tb.sv
